// File: rtl/core/bsl_pkg.sv
package bsl_pkg;

    // Number of record slots in the list
    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    // Width used when comparing counts against the 5-bit fields
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // Fixed field widths
    localparam int CAP_W  = 5;
    localparam int REQ_W  = 3;
    localparam int POS_W  = 5;
    localparam int ECNT_W = 5;
    localparam int SLOT_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [REQ_W-1:0] {
        REQ_FRONT  = 3'd0,
        REQ_AT     = 3'd1,
        REQ_BACK   = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_DUMP   = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One process record
    typedef struct packed {
        logic [15:0] pid;
        logic [15:0] run_time;
        logic [7:0]  prio;
        logic [31:0] sec;
        logic [19:0] usec;
    } rec_t;

    // Broadcast control from the list controller to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] held;
    } cell_ctrl_t;

endpackage

// File: rtl/core/bsl_if.sv
// Request channel
interface bsl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [4:0]  position;
    logic [15:0] new_pid;
    logic [15:0] new_run_time;
    logic [7:0]  new_priority;
    logic [31:0] new_created_sec;
    logic [19:0] new_created_usec;

    modport source (output valid, req_type, position, new_pid, new_run_time,
                    new_priority, new_created_sec, new_created_usec,
                    input ready);
    modport sink (input valid, req_type, position, new_pid, new_run_time,
                  new_priority, new_created_sec, new_created_usec,
                  output ready);
endinterface

// Response channel
interface bsl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [3:0]  slot;
    logic [15:0] slot_pid;
    logic [15:0] slot_run_time;
    logic [7:0]  slot_priority;
    logic [31:0] slot_created_sec;
    logic [19:0] slot_created_usec;
    logic        last;

    modport source (output valid, status, entry_count, slot, slot_pid, slot_run_time,
                    slot_priority, slot_created_sec, slot_created_usec, last,
                    input ready);
    modport sink (input valid, status, entry_count, slot, slot_pid, slot_run_time,
                  slot_priority, slot_created_sec, slot_created_usec, last,
                  output ready);
endinterface

// Capacity write channel
interface bsl_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/bsl_cell.sv
module bsl_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bsl_pkg::IDX_W-1:0] my_idx,
    input  bsl_pkg::cell_ctrl_t       ctrl,
    input  bsl_pkg::rec_t             left,
    input  bsl_pkg::rec_t             new_rec,
    output bsl_pkg::rec_t             rec
);

    bsl_pkg::rec_t              rec_reg;
    bsl_pkg::rec_t              rec_next;
    logic [bsl_pkg::CNT_W-1:0]  my_pos;

    assign my_pos = bsl_pkg::CNT_W'(my_idx);

    // Pick new record, left neighbor, clear, or hold
    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.ins && my_idx == ctrl.idx)
        begin
            rec_next = new_rec;
        end
        else if (ctrl.ins && my_idx > ctrl.idx && my_pos <= ctrl.held)
        begin
            rec_next = left;
        end
        else if (ctrl.rem && my_pos == ctrl.held - bsl_pkg::CNT_W'(1))
        begin
            rec_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

// File: rtl/core/bounded_shift_list.sv
// Bounded ordered list of process records built as a row of cells.
// Channels: req carries one request transaction (insert front, insert at
// a one-based position, insert back, remove last, dump); rsp returns the
// result transactions; cfg writes the capacity register (always ready).
// Insert and remove: every cell loads from its left neighbor or the new
// record, or holds, and remove clears the last held slot; the single
// result is registered and shows on rsp in the cycle after the request
// is taken. Such requests can be taken every cycle while rsp keeps up.
// Dump: the request is taken, then one result per slot 0..capacity-1 is
// loaded into the output register, one per cycle while rsp keeps up, read
// from the cells by a slot counter; req is held off until the final
// result is loaded.
// When rsp stalls, the output register holds its transaction and req is
// held off; no result is lost.
// Reset clears every slot, the record count and the output valid, and
// sets the capacity to 16. Capacity 0 acts as 1, above the slot count
// as the slot count.
module bounded_shift_list (
    input  logic      clk,
    input  logic      rst_n,
    bsl_cfg_if.sink   cfg,
    bsl_req_if.sink   req,
    bsl_rsp_if.source rsp
);

    localparam int IDX_W = bsl_pkg::IDX_W;
    localparam int CNT_W = bsl_pkg::CNT_W;
    localparam int CMP_W = bsl_pkg::CMP_W;

    logic [bsl_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]          held_reg, held_next;
    logic                      dump_reg, dump_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic                      ov_reg, ov_next;

    bsl_pkg::status_t          st_reg, st_next;
    logic [bsl_pkg::ECNT_W-1:0] ecnt_reg, ecnt_next;
    logic [bsl_pkg::SLOT_W-1:0] slot_reg, slot_next;
    bsl_pkg::rec_t             orec_reg, orec_next;
    logic                      last_reg, last_next;

    logic [CMP_W-1:0]          cap_ext, pos_c, held_p1;
    logic [CNT_W-1:0]          eff_cap;
    logic                      full, empty, accept, out_free, load;
    bsl_pkg::cell_ctrl_t       ctrl;
    bsl_pkg::rec_t             new_rec;
    bsl_pkg::rec_t             rec_q [bsl_pkg::SLOTS];
    bsl_pkg::req_code_t        code;

    // Effective capacity and list status
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_ext > CMP_W'(bsl_pkg::SLOTS))
        begin
            eff_cap = CNT_W'(bsl_pkg::SLOTS);
        end
        else
        begin
            eff_cap = CNT_W'(cap_ext);
        end
    end

    assign full  = held_reg >= eff_cap;
    assign empty = held_reg == '0;

    // Handshakes
    assign cfg.ready = 1'b1;
    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = !dump_reg && out_free;
    assign accept    = req.valid && req.ready;
    assign code      = bsl_pkg::req_code_t'(req.req_type);

    assign new_rec.pid      = req.new_pid;
    assign new_rec.run_time = req.new_run_time;
    assign new_rec.prio     = req.new_priority;
    assign new_rec.sec      = req.new_created_sec;
    assign new_rec.usec     = req.new_created_usec;

    // Clamped insert position
    always_comb
    begin
        held_p1 = CMP_W'(held_reg) + CMP_W'(1);
        pos_c   = CMP_W'(req.position);
        if (pos_c == '0)
        begin
            pos_c = CMP_W'(1);
        end
        if (pos_c > held_p1)
        begin
            pos_c = held_p1;
        end
    end

    // Request decode and result formation
    always_comb
    begin
        ctrl       = '0;
        ctrl.held  = held_reg;
        held_next  = held_reg;
        dump_next  = dump_reg;
        cnt_next   = cnt_reg;
        load       = 1'b0;
        st_next    = bsl_pkg::ST_OK;
        orec_next  = '0;
        slot_next  = '0;
        last_next  = 1'b1;
        if (accept)
        begin
            unique case (code) inside
                bsl_pkg::REQ_FRONT, bsl_pkg::REQ_AT, bsl_pkg::REQ_BACK:
                begin
                    load = 1'b1;
                    if (full)
                    begin
                        st_next = bsl_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins  = 1'b1;
                        held_next = held_reg + CNT_W'(1);
                        if (code == bsl_pkg::REQ_FRONT)
                        begin
                            ctrl.idx = '0;
                        end
                        else if (code == bsl_pkg::REQ_BACK)
                        begin
                            ctrl.idx = IDX_W'(held_reg);
                        end
                        else
                        begin
                            ctrl.idx = IDX_W'(pos_c - CMP_W'(1));
                        end
                    end
                end
                bsl_pkg::REQ_REMOVE:
                begin
                    load = 1'b1;
                    if (empty)
                    begin
                        st_next = bsl_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.rem  = 1'b1;
                        held_next = held_reg - CNT_W'(1);
                    end
                end
                bsl_pkg::REQ_DUMP:
                begin
                    dump_next = 1'b1;
                    cnt_next  = '0;
                end
                default:
                begin
                    load = 1'b1;
                end
            endcase
        end
        else if (dump_reg && out_free)
        begin
            // Stream one slot per cycle while the output register is free
            load      = 1'b1;
            orec_next = rec_q[cnt_reg];
            slot_next = bsl_pkg::SLOT_W'(cnt_reg);
            last_next = (CNT_W'(cnt_reg) + CNT_W'(1)) == eff_cap;
            cnt_next  = cnt_reg + IDX_W'(1);
            if (last_next)
            begin
                dump_next = 1'b0;
            end
        end
        ecnt_next = bsl_pkg::ECNT_W'(held_next);
        ov_next   = load ? 1'b1 : (rsp.ready ? 1'b0 : ov_reg);
    end

    // Row of record cells
    for (genvar i = 0; i < bsl_pkg::SLOTS; i++)
    begin : g_cell
        bsl_pkg::rec_t left;
        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_rest
            assign left = rec_q[i-1];
        end
        bsl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .my_idx  (IDX_W'(i)),
            .ctrl    (ctrl),
            .left    (left),
            .new_rec (new_rec),
            .rec     (rec_q[i])
        );
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= bsl_pkg::CAP_RESET;
            held_reg <= '0;
            dump_reg <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            held_reg <= held_next;
            dump_reg <= dump_next;
            cnt_reg  <= cnt_next;
            ov_reg   <= ov_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg   <= st_next;
            ecnt_reg <= ecnt_next;
            slot_reg <= slot_next;
            orec_reg <= orec_next;
            last_reg <= last_next;
        end
    end

    assign rsp.valid             = ov_reg;
    assign rsp.status            = st_reg;
    assign rsp.entry_count       = ecnt_reg;
    assign rsp.slot              = slot_reg;
    assign rsp.slot_pid          = orec_reg.pid;
    assign rsp.slot_run_time     = orec_reg.run_time;
    assign rsp.slot_priority     = orec_reg.prio;
    assign rsp.slot_created_sec  = orec_reg.sec;
    assign rsp.slot_created_usec = orec_reg.usec;
    assign rsp.last              = last_reg;

    // Assertions
    a_no_req_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        dump_reg |-> !req.ready)
        else $error("request taken during dump");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(bsl_pkg::SLOTS))
        else $error("record count above slot count");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full && (code == bsl_pkg::REQ_FRONT || code == bsl_pkg::REQ_AT
         || code == bsl_pkg::REQ_BACK))
        |=> held_reg == $past(held_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !empty && code == bsl_pkg::REQ_REMOVE)
        |=> held_reg == $past(held_reg) - CNT_W'(1))
        else $error("remove did not shrink the list");

endmodule

// File: dv/tb_bounded_shift_list.sv
`timescale 1ns / 100ps

module tb_bounded_shift_list;

    import bsl_pkg::*;

    // Run guard, far above the slowest legal run (about 180 requests, dumps of
    // up to 16 results, 56 percent stalls on each side in turn, one long hold-off)
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [19:0]      USEC_MAX      = 20'd999999;
    localparam logic [CAP_W-1:0] CAP_ZERO      = '0;
    localparam logic [CAP_W-1:0] CAP_ALL_ONES  = '1;
    localparam logic [POS_W-1:0] POS_ZERO      = '0;
    localparam logic [POS_W-1:0] POS_ALL_ONES  = '1;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_DUMP + 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = '1;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        rec_t             rec;
    } list_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ECNT_W-1:0] count;
        logic [SLOT_W-1:0] slot;
        rec_t              rec;
        logic              last;
    } list_reply_t;

    logic clk;
    logic rst_n;

    bsl_cfg_if cfg_ch();
    bsl_req_if req_ch();
    bsl_rsp_if rsp_ch();

    bounded_shift_list DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list
    rec_t             shadow_slots [SLOTS];
    int               shadow_held;
    logic [CAP_W-1:0] shadow_cap;

    list_reply_t owed_replies [$];
    int          err_count;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          rx_hold_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Response side ready: long hold-off first, else random stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic int active_cap();
        int c;
        c = shadow_cap;
        if (c == 0)
            c = 1;
        if (c > SLOTS)
            c = SLOTS;
        return c;
    endfunction

    function automatic void owe_single(input status_t st);
        list_reply_t r;
        r        = '0;
        r.status = st;
        r.count  = shadow_held[ECNT_W-1:0];
        r.last   = 1'b1;
        owed_replies.push_back(r);
    endfunction

    // Update the shadow list for one accepted request and queue its replies
    function automatic void apply_list_op(input list_req_t rq);
        int          cap;
        int          idx;
        int          p;
        list_reply_t r;
        cap = active_cap();
        if (rq.kind <= REQ_BACK)
        begin
            if (shadow_held >= cap)
                owe_single(ST_FULL);
            else
            begin
                if (rq.kind == REQ_FRONT)
                    idx = 0;
                else if (rq.kind == REQ_BACK)
                    idx = shadow_held;
                else
                begin
                    // position is one-based, clamped to 1..held+1
                    p = rq.pos;
                    if (p < 1)
                        p = 1;
                    if (p > shadow_held + 1)
                        p = shadow_held + 1;
                    idx = p - 1;
                end
                for (int i = shadow_held; i > idx; i--)
                    shadow_slots[i] = shadow_slots[i-1];
                shadow_slots[idx] = rq.rec;
                shadow_held++;
                owe_single(ST_OK);
            end
        end
        else if (rq.kind == REQ_REMOVE)
        begin
            if (shadow_held == 0)
                owe_single(ST_EMPTY);
            else
            begin
                shadow_held--;
                shadow_slots[shadow_held] = '0;
                owe_single(ST_OK);
            end
        end
        else if (rq.kind == REQ_DUMP)
        begin
            for (int i = 0; i < cap; i++)
            begin
                r        = '0;
                r.status = ST_OK;
                r.count  = shadow_held[ECNT_W-1:0];
                r.slot   = i[SLOT_W-1:0];
                r.rec    = shadow_slots[i];
                r.last   = (i == cap - 1);
                owed_replies.push_back(r);
            end
        end
        else
            owe_single(ST_OK);  // unused code: no effect
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // Reply checker
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_replies.size() == 0)
            begin
                $error("reply transaction with nothing outstanding");
                err_count++;
            end
            else
            begin
                want = owed_replies.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("entry_count", want.count, rsp_ch.entry_count);
                check_field("slot", want.slot, rsp_ch.slot);
                check_field("slot_pid", want.rec.pid, rsp_ch.slot_pid);
                check_field("slot_run_time", want.rec.run_time, rsp_ch.slot_run_time);
                check_field("slot_priority", want.rec.prio, rsp_ch.slot_priority);
                check_field("slot_created_sec", want.rec.sec, rsp_ch.slot_created_sec);
                check_field("slot_created_usec", want.rec.usec, rsp_ch.slot_created_usec);
                check_field("last", want.last, rsp_ch.last);
            end
        end
    end

    // Entered and left at a falling edge; valid stays high on return so a
    // following request can go out back to back
    task automatic send_request(input list_req_t rq);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.req_type         <= rq.kind;
        req_ch.position         <= rq.pos;
        req_ch.new_pid          <= rq.rec.pid;
        req_ch.new_run_time     <= rq.rec.run_time;
        req_ch.new_priority     <= rq.rec.prio;
        req_ch.new_created_sec  <= rq.rec.sec;
        req_ch.new_created_usec <= rq.rec.usec;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_list_op(rq);
        @(negedge clk);
    endtask

    // Sender pauses until every reply is in, then lets the block settle
    task automatic drain(input int settle);
        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain(4);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        shadow_cap = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic list_req_t mk_req(input logic [REQ_W-1:0] kind,
                                         input logic [POS_W-1:0] pos, input rec_t rec);
        list_req_t rq;
        rq.kind = kind;
        rq.pos  = pos;
        rq.rec  = rec;
        return rq;
    endfunction

    function automatic rec_t rec_max();
        rec_t r;
        r.pid      = '1;
        r.run_time = '1;
        r.prio     = '1;
        r.sec      = '1;
        r.usec     = USEC_MAX;
        return r;
    endfunction

    function automatic rec_t rand_rec();
        rec_t r;
        r.pid      = $urandom();
        r.run_time = $urandom();
        r.prio     = $urandom();
        r.sec      = $urandom();
        r.usec     = $urandom_range(0, USEC_MAX);
        case ($urandom_range(0, 7))
            0: r = rec_max();
            1: r = '0;
            default: ;
        endcase
        return r;
    endfunction

    // Random mix: insert_pct decides whether the list tends to fill or drain
    task automatic random_traffic(input int n, input int insert_pct);
        list_req_t rq;
        int        pick;
        repeat (n)
        begin
            rq.rec = rand_rec();
            if ($urandom_range(0, 3) == 0)
                rq.pos = $urandom();
            else
                rq.pos = $urandom_range(0, shadow_held + 1);
            if ($urandom_range(0, 99) < insert_pct)
                rq.kind = $urandom_range(REQ_FRONT, REQ_BACK);
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    rq.kind = REQ_REMOVE;
                else if (pick < 9)
                    rq.kind = REQ_DUMP;
                else
                    rq.kind = $urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI);
            end
            send_request(rq);
        end
    endtask

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // empty list: full-size dump of cleared slots, removal rejected
        send_request(mk_req(REQ_DUMP, POS_ZERO, '0));
        send_request(mk_req(REQ_REMOVE, POS_ZERO, rec_max()));
        // every insert flavor, clamped positions at both ends
        send_request(mk_req(REQ_FRONT, POS_ALL_ONES, rec_max()));
        send_request(mk_req(REQ_BACK, POS_ZERO, '0));
        send_request(mk_req(REQ_AT, POS_ZERO, rand_rec()));
        send_request(mk_req(REQ_AT, POS_ALL_ONES, rand_rec()));
        send_request(mk_req(REQ_AT, 5'd2, rand_rec()));
        // unused request codes are ignored
        send_request(mk_req(REQ_UNUSED_LO, POS_ALL_ONES, rec_max()));
        send_request(mk_req(REQ_UNUSED_HI, POS_ZERO, rec_max()));
        send_request(mk_req(REQ_DUMP, POS_ZERO, '0));
        // capacity below held count: inserts full, short dump, removal works
        write_capacity(5'd3);
        send_request(mk_req(REQ_FRONT, POS_ZERO, rand_rec()));
        send_request(mk_req(REQ_DUMP, POS_ZERO, '0));
        send_request(mk_req(REQ_REMOVE, POS_ZERO, '0));
        send_request(mk_req(REQ_REMOVE, POS_ZERO, '0));
        send_request(mk_req(REQ_REMOVE, POS_ZERO, '0));
        send_request(mk_req(REQ_BACK, POS_ZERO, rand_rec()));
        send_request(mk_req(REQ_AT, 5'd1, rand_rec()));
        // capacity zero behaves as one
        write_capacity(CAP_ZERO);
        send_request(mk_req(REQ_DUMP, POS_ZERO, '0));
        send_request(mk_req(REQ_REMOVE, POS_ZERO, '0));
        send_request(mk_req(REQ_REMOVE, POS_ZERO, '0));
        send_request(mk_req(REQ_REMOVE, POS_ZERO, '0));
        send_request(mk_req(REQ_FRONT, POS_ZERO, rec_max()));
        send_request(mk_req(REQ_BACK, POS_ZERO, rand_rec()));
        // capacity above the slot count behaves as the slot count
        write_capacity(CAP_ALL_ONES);
        send_request(mk_req(REQ_DUMP, POS_ZERO, '0));
    endtask

    task automatic test_random_phases();
        int               tx_pct [4] = '{0, 56, 0, 25};
        int               rx_pct [4] = '{0, 0, 56, 25};
        logic [CAP_W-1:0] cap;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: cap = CAP_RESET;
                1: cap = $urandom_range(2, SLOTS - 1);
                2: cap = CAP_ALL_ONES;
                default: cap = $urandom_range(1, 4);
            endcase
            write_capacity(cap);
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            random_traffic(17, 70);
            random_traffic(18, 35);
        end
    endtask

    task automatic test_backpressure();
        write_capacity(CAP_RESET);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // hold the reply side off while requests keep coming
        @(posedge clk);
        rx_hold_left = 80;
        @(negedge clk);
        random_traffic(6, 80);
        send_request(mk_req(REQ_DUMP, POS_ZERO, '0));
        random_traffic(5, 50);
        drain(2);
        tx_idle_pct  = 25;
        rx_stall_pct = 25;
        random_traffic(6, 50);
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        err_count               = 0;
        tx_idle_pct             = 0;
        rx_stall_pct            = 0;
        rx_hold_left            = 0;
        shadow_cap              = CAP_RESET;
        shadow_held             = 0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.data             = '0;
        req_ch.valid            = 1'b0;
        req_ch.req_type         = '0;
        req_ch.position         = '0;
        req_ch.new_pid          = '0;
        req_ch.new_run_time     = '0;
        req_ch.new_priority     = '0;
        req_ch.new_created_sec  = '0;
        req_ch.new_created_usec = '0;
        for (int i = 0; i < SLOTS; i++)
            shadow_slots[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_phases();
        test_backpressure();

        drain(20);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/bsl_pkg.sv
rtl/core/bsl_if.sv
rtl/core/bsl_cell.sv
rtl/core/bounded_shift_list.sv
dv/tb_bounded_shift_list.sv
